// File: src/psg_pkg.sv
package psg_pkg;

  localparam int LIMIT_W     = 9;
  localparam int PRIME_W     = 8;
  localparam int MARK_W      = LIMIT_W + 1;
  localparam int PRIME_RANGE = 256;
  localparam int DEFAULT_MAX_N = 256;
  localparam logic [LIMIT_W-1:0] FIRST_PRIME = LIMIT_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_CHECK,
    ST_MARK,
    ST_FLUSH
  } state_e;

endpackage

// File: src/psg_bitmap.sv
module psg_bitmap #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic          wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic          rd_data_o
);

  logic mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: src/prime_sieve_generator.sv
// Sieve of Eratosthenes over one limit word at a time. A limit word on the
// input channel starts a run. Every prime strictly below the limit leaves on
// the output channel as one word, in ascending order, with last_o set on the
// largest one. A limit of 2 or less gives no output word at all. A limit above
// the smaller of MAX_N and 256 is clamped to that value. The composite flags
// live in a one-bit-wide synchronous memory of MAX_N entries, with one write
// port and one read port. A run goes through these steps:
//   - clearing the map writes a zero to each entry below the limit
//   - each candidate gets a memory read and then a check
//   - each prime p marks its multiples 2p, 3p, ... below the limit
// A stalled output can hold the sieve at the next prime found. The input
// stalls for the whole run. It takes the next limit once the final prime sits
// in the output register, so the output may still be waiting while a new run
// starts.
module prime_sieve_generator
  #(
  parameter int MAX_N = psg_pkg::DEFAULT_MAX_N
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [psg_pkg::LIMIT_W-1:0]  limit_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [psg_pkg::PRIME_W-1:0]  prime_o,
  output logic                         last_o
);

  import psg_pkg::*;

  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam logic [LIMIT_W-1:0] LIM_CAP =
    (MAX_N < PRIME_RANGE) ? LIMIT_W'(MAX_N) : LIMIT_W'(PRIME_RANGE);

  state_e state_q, state_d;

  logic [LIMIT_W-1:0] lim_q, lim_d;     // effective limit of this run
  logic [LIMIT_W-1:0] cand_q, cand_d;   // candidate under test
  logic [MARK_W-1:0]  mark_q, mark_d;   // multiple being marked
  logic [LIMIT_W-1:0] clr_q, clr_d;     // clear sweep pointer
  logic               pend_valid_q, pend_valid_d;
  logic [PRIME_W-1:0] pend_q, pend_d;   // prime held back until its successor is known
  logic               out_valid_q, out_valid_d;
  logic [PRIME_W-1:0] prime_q, prime_d;
  logic               last_q, last_d;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               wr_data;
  logic               rd_en;
  logic               rd_data;

  logic [LIMIT_W-1:0] eff_lim;
  logic               out_free;
  logic               push_ok;

  assign eff_lim  = (limit_i > LIM_CAP) ? LIM_CAP : limit_i;
  // output register can take a word this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // a new prime may retire the pending one
  assign push_ok  = !pend_valid_q || out_free;

  assign rd_en = (state_q == ST_READ) && (cand_q < lim_q);

  psg_bitmap #(
    .DEPTH (MAX_N),
    .AW    (AW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (cand_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (clr_q >= lim_q) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = (cand_q >= lim_q) ? ST_FLUSH : ST_CHECK;
      end
      ST_CHECK: begin
        if (rd_data) begin
          state_d = ST_READ;
        end else if (push_ok) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        if (mark_q >= {1'b0, lim_q}) state_d = ST_READ;
      end
      ST_FLUSH: begin
        if (push_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    lim_d        = lim_q;
    cand_d       = cand_q;
    mark_d       = mark_q;
    clr_d        = clr_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && out_stall_i;
    prime_d      = prime_q;
    last_d       = last_q;
    wr_en        = 1'b0;
    wr_addr      = clr_q[AW-1:0];
    wr_data      = 1'b0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          lim_d        = eff_lim;
          clr_d        = '0;
          cand_d       = FIRST_PRIME;
          pend_valid_d = 1'b0;
        end
      end
      ST_CLEAR: begin
        if (clr_q < lim_q) begin
          wr_en   = 1'b1;
          wr_addr = clr_q[AW-1:0];
          wr_data = 1'b0;
          clr_d   = clr_q + LIMIT_W'(1);
        end
      end
      ST_READ: begin
      end
      ST_CHECK: begin
        if (rd_data) begin
          cand_d = cand_q + LIMIT_W'(1);
        end else if (push_ok) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            prime_d     = pend_q;
            last_d      = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_d       = cand_q[PRIME_W-1:0];
          mark_d       = {cand_q, 1'b0};
        end
      end
      ST_MARK: begin
        if (mark_q < {1'b0, lim_q}) begin
          wr_en   = 1'b1;
          wr_addr = mark_q[AW-1:0];
          wr_data = 1'b1;
          mark_d  = mark_q + {1'b0, cand_q};
        end else begin
          cand_d = cand_q + LIMIT_W'(1);
        end
      end
      ST_FLUSH: begin
        if (pend_valid_q && out_free) begin
          out_valid_d  = 1'b1;
          prime_d      = pend_q;
          last_d       = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lim_q        <= '0;
      cand_q       <= FIRST_PRIME;
      mark_q       <= '0;
      clr_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      lim_q        <= lim_d;
      cand_q       <= cand_d;
      mark_q       <= mark_d;
      clr_q        <= clr_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    prime_q <= prime_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign prime_o     = prime_q;
  assign last_o      = last_q;

endmodule

// File: sim/tb_prime_sieve_generator.sv
module tb_prime_sieve_generator;
  import psg_pkg::*;

  localparam int SIEVE_SIZE  = DEFAULT_MAX_N;
  localparam int ITEM_COUNT  = 350;
  localparam int IDLE_LIMIT  = 20000;  // cycles with no handshake on either side
  localparam int DRAIN_WAIT  = 1600;   // extra wait after the last expected word has arrived
  localparam int HOLD_CYCLES = 3000;   // long receiver hold-off
  localparam int HOLD_AFTER  = 120;    // words sent before the hold-off starts
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic               last;
  } prime_word_t;

  class sieve_checker;
    prime_word_t pending_primes[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    task report(input string msg);
      if (fail_count < PRINT_CAP) $display("mismatch: %s", msg);
      fail_count++;
    endtask

    // sieve of the clamped limit, one expected word per prime
    function void note_limit(input logic [LIMIT_W-1:0] raw);
      int unsigned bound;
      int unsigned m;
      int unsigned found[$];
      bit [PRIME_RANGE-1:0] crossed;
      prime_word_t w;
      bound = raw;
      if (bound > SIEVE_SIZE) bound = SIEVE_SIZE;
      if (bound > PRIME_RANGE) bound = PRIME_RANGE;
      crossed = '0;
      for (int unsigned p = FIRST_PRIME; p < bound; p++) begin
        if (!crossed[p]) begin
          found.insert(found.size(), p);
          for (m = p + p; m < bound; m += p) crossed[m] = 1'b1;
        end
      end
      foreach (found[i]) begin
        w.prime = PRIME_W'(found[i]);
        w.last  = (i == found.size() - 1);
        pending_primes.insert(pending_primes.size(), w);
      end
    endfunction

    task check_word(input logic [PRIME_W-1:0] prime, input logic last);
      prime_word_t exp_w;
      if (pending_primes.size() == 0) begin
        report($sformatf("unexpected word prime=%0d last=%0b", prime, last));
      end else begin
        exp_w = pending_primes.pop_front();
        if (prime !== exp_w.prime)
          report($sformatf("prime got %0d want %0d", prime, exp_w.prime));
        if (last !== exp_w.last)
          report($sformatf("last got %0b want %0b on prime %0d", last, exp_w.last,
                           exp_w.prime));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [LIMIT_W-1:0] limit_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [PRIME_W-1:0] prime_o;
  logic               last_o;

  sieve_checker board = new();
  int unsigned  items_sent = 0;
  int unsigned  idle_cycles = 0;

  prime_sieve_generator #(.MAX_N(SIEVE_SIZE)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .limit_i     (limit_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prime_o     (prime_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // handshake monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_limit(limit_i);
      if (out_valid_o && !out_stall_i) board.check_word(prime_o, last_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // offer one limit word and hold it until taken; returns at a falling edge
  task automatic drive_limit(input logic [LIMIT_W-1:0] lim);
    in_valid_i <= 1'b1;
    limit_i    <= lim;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // receiver: random stall modes, one long hold-off
  initial begin : receiver
    int unsigned mode;
    int unsigned seg_left;
    int unsigned period;
    int unsigned duty;
    int unsigned phase;
    int unsigned hold_left;
    bit          hold_done;
    seg_left  = 0;
    hold_left = 0;
    hold_done = 0;
    mode      = 0;
    period    = 1;
    duty      = 0;
    phase     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
          period   = $urandom_range(2, 9);
          duty     = $urandom_range(1, period - 1);
          phase    = 0;
        end
        seg_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 1) == 1);
          2: out_stall_i <= ($urandom_range(0, 9) == 0);
          default: begin
            out_stall_i <= (phase < duty);
            phase = (phase + 1) % period;
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    // edge limits: no prime, single prime, clamp and all-ones / all-zeros
    int directed_limits[16] = '{0, 1, 2, 3, 4, 5, 7, 8, 13, 97, 128, 255,
                                256, 257, 300, 511};
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    logic [LIMIT_W-1:0] lim;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    idx = 0;
    while (idx < 16 + ITEM_COUNT) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && idx < 16 + ITEM_COUNT) begin
        if (idx < 16) begin
          lim = LIMIT_W'(directed_limits[idx]);
        end else begin
          // mostly short runs, a few full-size and clamped ones
          pick = $urandom_range(0, 99);
          if (pick < 78) lim = LIMIT_W'($urandom_range(0, 64));
          else if (pick < 90) lim = LIMIT_W'($urandom_range(65, 255));
          else if (pick < 96) lim = LIMIT_W'(256);
          else lim = LIMIT_W'($urandom_range(257, 511));
        end
        drive_limit(lim);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        limit_i    <= LIMIT_W'($urandom);
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (board.pending_primes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (board.pending_primes.size() != 0)
      board.report($sformatf("%0d expected words never arrived",
                             board.pending_primes.size()));

    if (board.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
